// ----- rtl/fccm_pkg.sv -----
// Shared types, constants and control-store contents of the cluster chain manager.
package fccm_pkg;

  localparam int NUM_CLUSTERS = 4096;
  localparam int CL_W         = $clog2(NUM_CLUSTERS);
  localparam int CNT_W        = CL_W + 1;

  localparam int ACTION_W = 3;
  localparam int CLUSTER_W = 12;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int EMARK_W  = 28;

  localparam logic [VALUE_W-1:0] END_LIMIT  = 32'h0fff_fff8;
  localparam logic [CNT_W-1:0]   FIRST_DATA = CNT_W'(2);
  localparam logic [EMARK_W-1:0] EMARK_RST  = 28'hfff_ffff;

  localparam logic [ACTION_W-1:0] ACT_LOAD   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_EXTEND = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CLUSTER_W-1:0] cluster;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   count;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
  } out_t;

  // Control store addresses
  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_LOAD, S_READ, S_NEXT, S_EMIT, S_RANGE, S_FULL,
    S_AL0, S_AL1, S_AL2, S_L0, S_L1, S_L2, S_LFULL, S_LEND, S_WALK
  } step_t;

  typedef enum logic [2:0] {
    C_NONE, C_RD_ZERO, C_RD_END, C_WALK_BAD, C_CAND_LAST, C_CNT_ZERO, C_CNT_ONE
  } cond_sel_t;

  typedef enum logic [1:0] {RD_IN, RD_CUR, RD_CANDN, RD_WALK} rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_CUR_VALUE, WR_CUR_CAND, WR_CUR_END, WR_CAND_END, WR_CAND_ZERO
  } wr_sel_t;

  typedef enum logic [1:0] {CA_HOLD, CA_SET2, CA_INC, CA_INC_NZ} cand_op_t;
  typedef enum logic [1:0] {CU_HOLD, CU_CAND, CU_WALK} cur_op_t;
  typedef enum logic [2:0] {RS_HOLD, RS_RDATA, RS_NEXT, RS_CAND, RS_CUR_EXT} res_op_t;
  typedef enum logic [1:0] {SS_HOLD, SS_FULL, SS_RANGE} stat_op_t;

  typedef struct packed {
    rd_sel_t   rd_sel;
    wr_sel_t   wr_sel;
    cand_op_t  cand_op;
    cur_op_t   cur_op;
    logic      cnt_dec;
    logic      steps_inc;
    res_op_t   res_op;
    stat_op_t  stat_op;
    logic      emit;
    logic      wait_in;
    cond_sel_t ca;
    step_t     ta;
    cond_sel_t cb;
    step_t     tb;
    step_t     tn;
  } ctl_t;

  typedef struct packed {
    logic rd_zero;
    logic rd_end;
    logic walk_bad;
    logic cand_last;
    logic cnt_zero;
    logic cnt_one;
    logic busy;
    logic range_bad;
  } cond_t;

  // Control store: one word per step
  function automatic ctl_t ucode(input step_t pc);
    ctl_t c;
    c = '0;
    c.tn = S_IDLE;
    unique case (pc)
      S_IDLE: begin
        c.wait_in = 1'b1;
      end
      S_CLR: begin
        c.wr_sel = WR_CAND_ZERO;
        c.cand_op = CA_INC;
        c.ca = C_CAND_LAST;
        c.ta = S_IDLE;
        c.tn = S_CLR;
      end
      S_LOAD: begin
        c.wr_sel = WR_CUR_VALUE;
        c.emit = 1'b1;
      end
      S_READ: begin
        c.rd_sel = RD_CUR;
        c.res_op = RS_RDATA;
        c.emit = 1'b1;
      end
      S_NEXT: begin
        c.rd_sel = RD_CUR;
        c.res_op = RS_NEXT;
        c.emit = 1'b1;
      end
      S_EMIT: begin
        c.emit = 1'b1;
      end
      S_RANGE: begin
        c.stat_op = SS_RANGE;
        c.emit = 1'b1;
      end
      S_FULL: begin
        c.stat_op = SS_FULL;
        c.emit = 1'b1;
      end
      S_AL0: begin
        c.rd_sel = RD_CANDN;
        c.cand_op = CA_SET2;
        c.tn = S_AL1;
      end
      S_AL1: begin
        c.rd_sel = RD_CANDN;
        c.cand_op = CA_INC_NZ;
        c.ca = C_RD_ZERO;
        c.ta = S_AL2;
        c.cb = C_CAND_LAST;
        c.tb = S_FULL;
        c.tn = S_AL1;
      end
      S_AL2: begin
        c.wr_sel = WR_CAND_END;
        c.cur_op = CU_CAND;
        c.res_op = RS_CAND;
        c.cnt_dec = 1'b1;
        c.tn = S_L0;
      end
      S_L0: begin
        c.rd_sel = RD_CANDN;
        c.cand_op = CA_SET2;
        c.ca = C_CNT_ZERO;
        c.ta = S_LEND;
        c.tn = S_L1;
      end
      S_L1: begin
        c.rd_sel = RD_CANDN;
        c.cand_op = CA_INC_NZ;
        c.ca = C_RD_ZERO;
        c.ta = S_L2;
        c.cb = C_CAND_LAST;
        c.tb = S_LFULL;
        c.tn = S_L1;
      end
      S_L2: begin
        c.rd_sel = RD_CANDN;
        c.wr_sel = WR_CUR_CAND;
        c.cur_op = CU_CAND;
        c.cand_op = CA_INC;
        c.cnt_dec = 1'b1;
        c.ca = C_CNT_ONE;
        c.ta = S_LEND;
        c.cb = C_CAND_LAST;
        c.tb = S_LFULL;
        c.tn = S_L1;
      end
      S_LFULL: begin
        c.stat_op = SS_FULL;
        c.tn = S_LEND;
      end
      S_LEND: begin
        c.wr_sel = WR_CUR_END;
        c.res_op = RS_CUR_EXT;
        c.emit = 1'b1;
      end
      S_WALK: begin
        c.rd_sel = RD_WALK;
        c.cur_op = CU_WALK;
        c.steps_inc = 1'b1;
        c.ca = C_RD_END;
        c.ta = S_L0;
        c.cb = C_WALK_BAD;
        c.tb = S_RANGE;
        c.tn = S_WALK;
      end
      default: begin
        c.tn = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/fccm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fccm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fccm_useq.sv -----
// Step counter, control store and jump logic of the cluster chain manager.
module fccm_useq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [fccm_pkg::ACTION_W-1:0] in_action,
  input  fccm_pkg::cond_t               cnd,
  output fccm_pkg::ctl_t                ctl
);
  import fccm_pkg::*;

  step_t pc;
  step_t pc_next;

  function automatic logic cond_hit(input cond_sel_t sel, input cond_t c);
    logic hit;
    hit = 1'b0;
    unique case (sel)
      C_NONE:      hit = 1'b0;
      C_RD_ZERO:   hit = c.rd_zero;
      C_RD_END:    hit = c.rd_end;
      C_WALK_BAD:  hit = c.walk_bad;
      C_CAND_LAST: hit = c.cand_last;
      C_CNT_ZERO:  hit = c.cnt_zero;
      C_CNT_ONE:   hit = c.cnt_one;
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic step_t entry(input logic [ACTION_W-1:0] act, input logic bad);
    step_t s;
    s = S_EMIT;
    priority if (bad) begin
      s = S_RANGE;
    end else begin
      unique case (act)
        ACT_LOAD:   s = S_LOAD;
        ACT_READ:   s = S_READ;
        ACT_NEXT:   s = S_NEXT;
        ACT_ALLOC:  s = S_AL0;
        ACT_EXTEND: s = S_WALK;
        default:    s = S_EMIT;
      endcase
    end
    return s;
  endfunction

  always_comb begin
    ctl = ucode(pc);
  end

  always_comb begin
    pc_next = pc;
    priority if (cnd.busy) begin
      pc_next = pc;
    end else if (ctl.wait_in) begin
      if (in_valid) begin
        pc_next = entry(in_action, cnd.range_bad);
      end
    end else if (cond_hit(ctl.ca, cnd)) begin
      pc_next = ctl.ta;
    end else if (cond_hit(ctl.cb, cnd)) begin
      pc_next = ctl.tb;
    end else begin
      pc_next = ctl.tn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- rtl/fccm_dpath.sv -----
// Datapath of the cluster chain manager: table RAM, chain registers, result register.
module fccm_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  fccm_pkg::in_t                in_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output fccm_pkg::out_t               out_data,
  input  logic                         cfg_wr_en,
  input  logic [fccm_pkg::EMARK_W-1:0] cfg_wr_data,
  input  fccm_pkg::ctl_t               ctl,
  output fccm_pkg::cond_t              cnd
);
  import fccm_pkg::*;

  logic [EMARK_W-1:0]  emark;
  logic [ACTION_W-1:0] act;
  logic [VALUE_W-1:0]  val;
  logic [CL_W-1:0]     cur;
  logic [CL_W-1:0]     cur_next;
  logic [CNT_W-1:0]    cand;
  logic [CNT_W-1:0]    cand_next;
  logic [CNT_W-1:0]    steps;
  logic [COUNT_W-1:0]  cnt;
  logic [VALUE_W-1:0]  res;
  logic [VALUE_W-1:0]  res_next;
  logic [STATUS_W-1:0] st;
  logic [STATUS_W-1:0] st_next;

  logic                accept;
  logic                advance;
  logic                busy;
  logic                rd_end;
  logic                we;
  logic [CL_W-1:0]     waddr;
  logic [VALUE_W-1:0]  wdata;
  logic [CL_W-1:0]     raddr;
  logic [VALUE_W-1:0]  rd_data;

  assign busy    = ctl.emit && out_valid && !out_ready;
  assign advance = !busy;
  assign accept  = in_valid && ctl.wait_in;
  assign rd_end  = rd_data >= END_LIMIT;

  always_comb begin
    cnd.rd_zero   = rd_data == '0;
    cnd.rd_end    = rd_end;
    cnd.walk_bad  = (rd_data >= VALUE_W'(NUM_CLUSTERS)) || (steps >= CNT_W'(NUM_CLUSTERS));
    cnd.cand_last = cand == CNT_W'(NUM_CLUSTERS - 1);
    cnd.cnt_zero  = cnt == '0;
    cnd.cnt_one   = cnt == COUNT_W'(1);
    cnd.busy      = busy;
    cnd.range_bad = ((in_data.action == ACT_LOAD) || (in_data.action == ACT_READ) ||
                     (in_data.action == ACT_NEXT) || (in_data.action == ACT_EXTEND)) &&
                    (VALUE_W'(in_data.cluster) >= VALUE_W'(NUM_CLUSTERS));
  end

  always_comb begin
    unique case (ctl.cand_op)
      CA_HOLD:   cand_next = cand;
      CA_SET2:   cand_next = FIRST_DATA;
      CA_INC:    cand_next = cand + 1'b1;
      CA_INC_NZ: cand_next = cnd.rd_zero ? cand : cand + 1'b1;
      default:   cand_next = cand;
    endcase
  end

  always_comb begin
    unique case (ctl.cur_op)
      CU_HOLD: cur_next = cur;
      CU_CAND: cur_next = cand[CL_W-1:0];
      CU_WALK: cur_next = rd_end ? cur : rd_data[CL_W-1:0];
      default: cur_next = cur;
    endcase
  end

  always_comb begin
    unique case (ctl.rd_sel)
      RD_IN:    raddr = CL_W'(in_data.cluster);
      RD_CUR:   raddr = cur;
      RD_CANDN: raddr = cand_next[CL_W-1:0];
      RD_WALK:  raddr = rd_data[CL_W-1:0];
      default:  raddr = cur;
    endcase
  end

  always_comb begin
    we    = advance;
    waddr = cur;
    wdata = '0;
    unique case (ctl.wr_sel)
      WR_NONE:      we = 1'b0;
      WR_CUR_VALUE: wdata = val;
      WR_CUR_CAND:  wdata = VALUE_W'(cand);
      WR_CUR_END:   wdata = VALUE_W'(emark);
      WR_CAND_END: begin
        waddr = cand[CL_W-1:0];
        wdata = VALUE_W'(emark);
      end
      WR_CAND_ZERO: waddr = cand[CL_W-1:0];
      default:      we = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctl.res_op)
      RS_HOLD:    res_next = res;
      RS_RDATA:   res_next = rd_data;
      RS_NEXT:    res_next = rd_end ? VALUE_W'(emark) : rd_data;
      RS_CAND:    res_next = VALUE_W'(cand);
      RS_CUR_EXT: res_next = (act == ACT_EXTEND) ? VALUE_W'(cur) : res;
      default:    res_next = res;
    endcase
  end

  always_comb begin
    unique case (ctl.stat_op)
      SS_HOLD:  st_next = st;
      SS_FULL:  st_next = STAT_FULL;
      SS_RANGE: st_next = STAT_RANGE;
      default:  st_next = st;
    endcase
  end

  fccm_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(NUM_CLUSTERS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (advance),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      emark     <= EMARK_RST;
      cand      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        emark <= cfg_wr_data;
      end
      if (advance) begin
        cand <= cand_next;
      end
      if (ctl.emit && advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and chain registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= in_data.action;
      val   <= in_data.value;
      cur   <= CL_W'(in_data.cluster);
      steps <= '0;
      res   <= '0;
      st    <= STAT_OK;
      if ((in_data.action == ACT_ALLOC) && (in_data.count == '0)) begin
        cnt <= COUNT_W'(1);
      end else begin
        cnt <= in_data.count;
      end
    end else if (advance) begin
      cur <= cur_next;
      res <= res_next;
      st  <= st_next;
      if (ctl.cnt_dec) begin
        cnt <= cnt - 1'b1;
      end
      if (ctl.steps_inc) begin
        steps <= steps + 1'b1;
      end
    end
    if (ctl.emit && advance) begin
      out_data.result_value <= res_next;
      out_data.status       <= st_next;
    end
  end

endmodule

// ----- rtl/fat_cluster_chain_manager.sv -----
// Top level of the FAT32 cluster chain manager: sequencer, datapath and checks.
//
// Keeps a 4096-entry table of 32-bit FAT32 entries (zero means free) in one
// RAM and serves one request at a time on a valid/ready input channel, giving
// one result beat per request on a valid/ready output channel. A small control
// store steps a plain datapath: a step counter, a register file of chain
// pointers and one RAM write port plus one registered read port. Loads, reads
// and next-cluster lookups go from the wait step to their own step, which
// registers the result beat; a new request is taken only back in the wait step.
// Allocate links count free clusters, found first-fit (zero counts as one), into
// a new chain; extend walks the chain to its end and then links on the same way.
// The first-fit search and the chain walk visit one table entry per cycle through
// the RAM read port. After reset the block sweeps the table to zero, one entry
// per cycle, so in_ready stays low until the sweep is done; end_marker writes are
// taken during that sweep. A result waiting in the output register does not
// hold off the next request; the block stalls only when it has a new result
// ready and the previous beat has not been taken.
module fat_cluster_chain_manager (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fccm_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fccm_pkg::out_t               out_data,
  input  logic                         cfg_wr_en,
  input  logic [fccm_pkg::EMARK_W-1:0] cfg_wr_data
);
  import fccm_pkg::*;

  ctl_t  ctl;
  cond_t cnd;

  // Take a new request only in the wait step of the program
  assign in_ready = ctl.wait_in;

  fccm_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .cnd       (cnd),
    .ctl       (ctl)
  );

  fccm_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .cnd         (cnd)
  );

  // Hold off requests while the clearing sweep starts after reset
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !in_ready)
    else $error("request port open right after reset");

  // An accepted beat moves the program out of the wait step
  a_one_beat_per_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken before the first finished");

  // A range error never carries a value
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == STAT_RANGE)) |-> (out_data.result_value == '0))
    else $error("range error with nonzero result");

  // A result beat appears only from an emitting step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.emit))
    else $error("result beat raised outside an emitting step");

endmodule

// ----- bench/chain_table_pkg.sv -----
`timescale 1ns / 100ps
// Shadow copy of the cluster table that predicts and checks each result beat.
package chain_table_pkg;
  import fccm_pkg::*;

  class chain_table_shadow;
    bit [VALUE_W-1:0] fat [NUM_CLUSTERS];
    bit [EMARK_W-1:0] end_mark;
    out_t             due_q [$];
    out_t             last;
    int               errors;
    int               beats;
    int               act_seen [8];
    int               stat_seen [4];

    function new();
      foreach (fat[i]) fat[i] = '0;
      foreach (act_seen[i]) act_seen[i] = 0;
      foreach (stat_seen[i]) stat_seen[i] = 0;
      end_mark = EMARK_RST;
      errors   = 0;
      beats    = 0;
      last     = '0;
    endfunction

    function void set_end_mark(input bit [EMARK_W-1:0] mark);
      end_mark = mark;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    // First free entry at or above start, NUM_CLUSTERS when none is left.
    function int free_from(input int start);
      for (int c = start; c < NUM_CLUSTERS; c++) begin
        if (fat[c] == '0) return c;
      end
      return NUM_CLUSTERS;
    endfunction

    // Append up to n first-fit clusters after tail, then terminate the chain.
    function int link_run(input int tail, input int n, output bit ran_out);
      int cur;
      int cand;
      int done;
      cur     = tail;
      cand    = int'(FIRST_DATA);
      done    = 0;
      ran_out = 1'b0;
      while (done < n) begin
        cand = free_from(cand);
        if (cand >= NUM_CLUSTERS) begin
          ran_out = 1'b1;
          break;
        end
        fat[cur] = VALUE_W'(cand);
        cur = cand;
        done++;
        cand++;
      end
      fat[cur] = VALUE_W'(end_mark);
      return cur;
    endfunction

    // Update the table for one accepted request and queue its result.
    function void apply_request(input in_t req);
      out_t             exp;
      int               idx;
      int               cnt;
      int               cur;
      int               steps;
      int               first;
      bit               ran_out;
      bit               bad;
      bit [VALUE_W-1:0] link;
      exp = '0;
      idx = int'(req.cluster);
      cnt = int'(req.count);
      act_seen[req.action]++;
      if ((req.action <= ACT_NEXT || req.action == ACT_EXTEND) && idx >= NUM_CLUSTERS) begin
        exp.status = STAT_RANGE;
      end else begin
        case (req.action)
          ACT_LOAD: fat[idx] = req.value;
          ACT_READ: exp.result_value = fat[idx];
          ACT_NEXT: begin
            exp.result_value = (fat[idx] >= END_LIMIT) ? VALUE_W'(end_mark) : fat[idx];
          end
          ACT_ALLOC: begin
            first = free_from(int'(FIRST_DATA));
            if (first >= NUM_CLUSTERS) begin
              exp.status = STAT_FULL;
            end else begin
              if (cnt == 0) cnt = 1;
              fat[first] = VALUE_W'(end_mark);
              void'(link_run(first, cnt - 1, ran_out));
              if (ran_out) exp.status = STAT_FULL;
              exp.result_value = VALUE_W'(first);
            end
          end
          ACT_EXTEND: begin
            cur   = idx;
            steps = 0;
            bad   = 1'b0;
            while (fat[cur] < END_LIMIT) begin
              link = fat[cur];
              if (link >= NUM_CLUSTERS || steps >= NUM_CLUSTERS) begin
                bad = 1'b1;
                break;
              end
              cur = int'(link);
              steps++;
            end
            if (bad) begin
              exp.status = STAT_RANGE;
            end else begin
              exp.result_value = VALUE_W'(link_run(cur, cnt, ran_out));
              if (ran_out) exp.status = STAT_FULL;
            end
          end
          default: ;
        endcase
      end
      last = exp;
      due_q.push_back(exp);
    endfunction

    // Compare one result beat with the oldest outstanding prediction.
    function void match_result(input out_t got);
      out_t exp;
      beats++;
      stat_seen[got.status]++;
      if (due_q.size() == 0) begin
        $error("unexpected result beat: result_value %h status %0d",
               got.result_value, got.status);
        errors++;
        return;
      end
      exp = due_q.pop_front();
      if (got.result_value !== exp.result_value) begin
        $error("result_value: expected %h, got %h", exp.result_value, got.result_value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: drives requests and end-marker writes, checks every result beat.
module tb_top;
  import fccm_pkg::*;
  import chain_table_pkg::*;

  // Long receiver hold-off, in cycles, used once to back up the block.
  localparam int     LONG_HOLD   = 300;
  // Quiet cycles after the last beat before an end-marker write or the verdict.
  localparam int     SETTLE      = 8;
  // Slowest legal item is roughly a full walk, a full scan and 8191 links.
  localparam longint CYCLE_LIMIT = 64'd50_000_000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_t                in_data;
  logic               out_valid;
  logic               out_ready;
  out_t               out_data;
  logic               cfg_wr_en;
  logic [EMARK_W-1:0] cfg_wr_data;

  chain_table_shadow    shadow;
  logic [CLUSTER_W-1:0] chain_heads [$];
  bit                   no_idle       = 1'b0;
  bit                   long_hold_req = 1'b0;
  int                   send_quiet    = 0;
  int                   stall_quiet   = 0;
  longint               cycles        = 0;

  fat_cluster_chain_manager DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fat_cluster_chain_manager test failed");
      $finish;
    end
  end

  // Check every result beat as it is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.match_result(out_data);
  end

  // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (!no_idle && stall_quiet == 0 && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        if (stall_quiet > 0) stall_quiet--;
        else if ($urandom_range(0, 39) == 0) stall_quiet = $urandom_range(20, 80);
        @(negedge clk);
      end
    end
  end

  function automatic in_t make_request(input logic [ACTION_W-1:0] act, input int cl,
                                       input logic [VALUE_W-1:0] val, input int n);
    in_t r;
    r.action  = act;
    r.cluster = CLUSTER_W'(cl);
    r.value   = val;
    r.count   = COUNT_W'(n);
    return r;
  endfunction

  // Offer one beat and hold it until taken; valid stays high on return so a
  // following beat can go out back to back. Call at a falling edge.
  task automatic offer(input in_t item);
    if (!no_idle && send_quiet == 0 && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end else if (send_quiet > 0) begin
      send_quiet--;
    end else if ($urandom_range(0, 29) == 0) begin
      send_quiet = $urandom_range(15, 60);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    shadow.apply_request(item);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted beat has come back.
  task automatic settle();
    in_valid = 1'b0;
    while (shadow.outstanding() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_end_mark(input logic [EMARK_W-1:0] mark);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mark;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    shadow.set_end_mark(mark);
  endtask

  // Favor known chain heads and low clusters so walks and reads hit live chains.
  function automatic int pick_cluster();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2 && chain_heads.size() != 0)
      return int'(chain_heads[$urandom_range(0, chain_heads.size() - 1)]);
    if (r == 2) return $urandom_range(0, 63);
    return $urandom_range(0, NUM_CLUSTERS - 1);
  endfunction

  // Mostly short chains, now and then a longer one.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 4);
    if (r < 19) return $urandom_range(5, 40);
    return $urandom_range(41, 300);
  endfunction

  // Load values: mostly frees, some in-table links, end values and raw words.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return '0;
    if (r < 15) return VALUE_W'($urandom_range(0, NUM_CLUSTERS - 1));
    if (r < 17) return END_LIMIT + VALUE_W'($urandom_range(0, 7));
    return VALUE_W'($urandom);
  endfunction

  // Remember a fresh chain head so later extends and lookups reach it.
  task automatic note_head();
    if (shadow.last.result_value != '0) begin
      chain_heads.push_back(CLUSTER_W'(shadow.last.result_value));
      if (chain_heads.size() > 24) void'(chain_heads.pop_front());
    end
  endtask

  task automatic random_requests(input int n);
    int  r;
    in_t item;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 14)
        item = make_request(ACT_LOAD, pick_cluster(), pick_value(), $urandom_range(0, 8191));
      else if (r < 28)
        item = make_request(ACT_READ, pick_cluster(), $urandom, $urandom_range(0, 8191));
      else if (r < 44)
        item = make_request(ACT_NEXT, pick_cluster(), $urandom, $urandom_range(0, 8191));
      else if (r < 70)
        item = make_request(ACT_ALLOC, $urandom_range(0, NUM_CLUSTERS - 1), $urandom,
                            pick_count());
      else if (r < 96)
        item = make_request(ACT_EXTEND, pick_cluster(), $urandom, pick_count());
      else
        item = make_request(ACTION_W'($urandom_range(5, 7)), $urandom_range(0, 4095),
                            $urandom, $urandom_range(0, 8191));
      offer(item);
      if (item.action == ACT_ALLOC) note_head();
    end
  endtask

  // Hand-picked opening on an empty table with the reset end marker.
  task automatic directed_requests();
    offer(make_request(ACT_READ,   0,    32'h0, 0));     // empty entry reads zero
    offer(make_request(ACT_NEXT,   4095, 32'h0, 0));     // free entry given as is
    offer(make_request(ACT_ALLOC,  0,    32'h0, 0));     // count zero acts as one
    offer(make_request(ACT_ALLOC,  0,    32'h0, 3));     // 3 -> 4 -> 5
    offer(make_request(ACT_EXTEND, 3,    32'h0, 0));     // rewrite the tail only
    offer(make_request(ACT_EXTEND, 2,    32'h0, 2));     // 2 -> 6 -> 7
    offer(make_request(ACT_NEXT,   3,    32'h0, 0));
    offer(make_request(ACT_NEXT,   7,    32'h0, 0));     // end entry gives the marker
    offer(make_request(ACT_LOAD,   4095, 32'hffff_ffff, 0));
    offer(make_request(ACT_READ,   4095, 32'h0, 0));
    offer(make_request(ACT_NEXT,   4095, 32'h0, 0));
    offer(make_request(ACT_LOAD,   10,   32'h0fff_fff7, 0));  // just under the end range
    offer(make_request(ACT_NEXT,   10,   32'h0, 0));
    offer(make_request(ACT_EXTEND, 10,   32'h0, 1));     // link leaves the table
    offer(make_request(ACT_LOAD,   20,   32'd20, 0));    // entry points at itself
    offer(make_request(ACT_EXTEND, 20,   32'h0, 5));     // walk never ends
    offer(make_request(ACT_LOAD,   6,    32'h0, 0));     // break chain 2 in the middle
    offer(make_request(ACT_EXTEND, 2,    32'h0, 1));     // walk falls into free cluster 0
    offer(make_request(ACT_LOAD,   0,    32'h0fff_fff8, 0));
    offer(make_request(ACT_EXTEND, 2,    32'h0, 1));     // now ends at 0, reuses 6
    offer(make_request(3'd5,       1,    32'h1234_5678, 7));
    offer(make_request(3'd6,       0,    32'h0, 0));
    offer(make_request(3'd7,       4095, 32'hffff_ffff, 8191));
  endtask

  initial begin
    logic [CLUSTER_W-1:0] head;
    logic [CLUSTER_W-1:0] second;
    int                   total;

    shadow      = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // The table sweep after reset takes end-marker writes; set the top value.
    write_end_mark(28'hfff_ffff);
    directed_requests();

    // Lowest legal end marker, random traffic with idling on both sides.
    settle();
    write_end_mark(END_LIMIT[EMARK_W-1:0]);
    random_requests(360);

    // End marker below the end range: terminators become links out of the table.
    settle();
    write_end_mark(28'hfff_fff0);
    offer(make_request(ACT_ALLOC, 0, 32'h0, 2));
    head = CLUSTER_W'(shadow.last.result_value);
    offer(make_request(ACT_NEXT, head, 32'h0, 0));
    second = CLUSTER_W'(shadow.last.result_value);
    offer(make_request(ACT_NEXT, second, 32'h0, 0));
    offer(make_request(ACT_EXTEND, head, 32'h0, 1));
    random_requests(30);

    // Random in-range marker; hold the receiver off midway so the block backs up.
    settle();
    write_end_mark(END_LIMIT[EMARK_W-1:0] + EMARK_W'($urandom_range(0, 7)));
    random_requests(100);
    long_hold_req = 1'b1;
    random_requests(130);

    // Final stretch without idling: fill the table, then work around a full table.
    settle();
    write_end_mark(28'hfff_fffc);
    no_idle = 1'b1;
    offer(make_request(ACT_ALLOC, 0, 32'h0, 4096));
    note_head();
    head = CLUSTER_W'(shadow.last.result_value);
    offer(make_request(ACT_ALLOC, 0, 32'h0, 1));        // nothing free at all
    offer(make_request(ACT_EXTEND, head, 32'h0, 3));    // runs out while linking
    random_requests(150);
    offer(make_request(ACT_ALLOC, 0, 32'h0, 8191));

    settle();
    repeat (20) @(negedge clk);

    total = 0;
    foreach (shadow.act_seen[i]) total += shadow.act_seen[i];
    $write("Run covered %0d requests: %0d load, %0d read, %0d next, ",
           total, shadow.act_seen[ACT_LOAD], shadow.act_seen[ACT_READ],
           shadow.act_seen[ACT_NEXT]);
    $display("%0d allocate, %0d extend, %0d unused",
             shadow.act_seen[ACT_ALLOC], shadow.act_seen[ACT_EXTEND],
             total - shadow.act_seen[ACT_LOAD] - shadow.act_seen[ACT_READ] -
             shadow.act_seen[ACT_NEXT] - shadow.act_seen[ACT_ALLOC] -
             shadow.act_seen[ACT_EXTEND]);
    $display("Checked %0d result beats (%0d ok, %0d no space, %0d out of range), %0d mismatches",
             shadow.beats, shadow.stat_seen[STAT_OK], shadow.stat_seen[STAT_FULL],
             shadow.stat_seen[STAT_RANGE], shadow.errors);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("fat_cluster_chain_manager test passed");
    end else begin
      $display("fat_cluster_chain_manager test failed");
    end
    $finish;
  end

endmodule
